// File: sv/ihac_pkg.sv
// shared types, constants and codes for the image header adler-32 checker
// no dependencies; every other file imports this package
package ihac_pkg;

  // header layout
  localparam int HEADER_BYTES = 16;
  localparam int COUNT_W      = 5;

  // adler-32
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // configuration registers
  localparam int CFG_W = 32;
  localparam logic [31:0] MARKER_RESET   = 32'h5354_5259;
  localparam logic [31:0] REVISION_RESET = 32'h0000_0000;

  typedef enum logic [0:0] {
    CFG_EXPECTED_MARKER    = 1'b0,
    CFG_INSTALLED_REVISION = 1'b1
  } cfg_index_t;

  // result status codes
  typedef enum logic [2:0] {
    STATUS_OK           = 3'd0,
    STATUS_SUM_MISMATCH = 3'd1,
    STATUS_OLD_VERSION  = 3'd2,
    STATUS_BAD_MARKER   = 3'd3,
    STATUS_TOO_SHORT    = 3'd4
  } status_t;

  // what a byte is, by its place in the image
  typedef enum logic [2:0] {
    KIND_MARKER  = 3'd0,
    KIND_SIZE    = 3'd1,
    KIND_VERSION = 3'd2,
    KIND_CHECK   = 3'd3,
    KIND_PAYLOAD = 3'd4
  } byte_kind_t;

  // input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // result item
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] computed_sum;
  } result_t;

  // classified item between front and back
  typedef struct packed {
    byte_kind_t kind;
    logic [1:0] lane;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       short_image;
  } tagged_t;

endpackage

// File: sv/ihac_front.sv
// front part: accepts image bytes, classifies them by header position,
// and holds them in a two-entry queue for the back part; uses ihac_pkg
module ihac_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  ihac_pkg::item_t      item,
  output logic                 tag_valid,
  input  logic                 tag_take,
  output ihac_pkg::tagged_t    tag
);
  import ihac_pkg::*;

  logic [COUNT_W-1:0] header_count;
  tagged_t            tag_new;
  tagged_t            slots [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               accept;
  logic               take;

  assign full      = (count == 2'd2);
  assign accept    = push && !full;
  assign tag_valid = (count != 2'd0);
  assign take      = tag_take && tag_valid;
  assign tag       = slots[rd_ptr];

  // classify by the number of header bytes taken so far
  always_comb begin
    tag_new.data_byte   = item.data_byte;
    tag_new.last_byte   = item.last_byte;
    tag_new.lane        = header_count[1:0];
    tag_new.short_image = item.last_byte &&
                          (header_count < COUNT_W'(HEADER_BYTES - 1));
    if (header_count < COUNT_W'(4)) begin
      tag_new.kind = KIND_MARKER;
    end else if (header_count < COUNT_W'(8)) begin
      tag_new.kind = KIND_SIZE;
    end else if (header_count < COUNT_W'(12)) begin
      tag_new.kind = KIND_VERSION;
    end else if (header_count < COUNT_W'(HEADER_BYTES)) begin
      tag_new.kind = KIND_CHECK;
    end else begin
      tag_new.kind = KIND_PAYLOAD;
    end
  end

  // header position counter, back to zero after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
    end else if (accept) begin
      if (item.last_byte) begin
        header_count <= '0;
      end else if (header_count < COUNT_W'(HEADER_BYTES)) begin
        header_count <= header_count + COUNT_W'(1);
      end
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, accept} - {1'b0, take};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= tag_new;
    end
  end

endmodule

// File: sv/ihac_back.sv
// back part: captures header words, runs adler-32 over the payload and
// builds the status on the last byte; uses ihac_pkg
module ihac_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tag_valid,
  output logic                 tag_take,
  input  ihac_pkg::tagged_t    tag,
  input  logic [31:0]          expected_marker,
  input  logic [31:0]          installed_revision,
  input  logic                 res_full,
  output logic                 res_push,
  output ihac_pkg::result_t    res
);
  import ihac_pkg::*;

  logic [31:0] header_marker;
  logic [31:0] header_version;
  logic [31:0] header_sum;
  logic [15:0] sum_low;
  logic [15:0] sum_high;

  logic [31:0] header_marker_next;
  logic [31:0] header_version_next;
  logic [31:0] header_sum_next;
  logic [15:0] sum_low_next;
  logic [15:0] sum_high_next;
  logic [16:0] low_raw;
  logic [16:0] high_raw;
  logic [16:0] low_red;
  logic [31:0] sum_word;
  logic        step;

  assign tag_take = tag_valid && !res_full;
  assign step     = tag_take;

  // header word capture, one byte lane at a time
  always_comb begin
    header_marker_next  = header_marker;
    header_version_next = header_version;
    header_sum_next     = header_sum;
    case (tag.kind)
      KIND_MARKER:  header_marker_next[{tag.lane, 3'b000} +: 8]  = tag.data_byte;
      KIND_VERSION: header_version_next[{tag.lane, 3'b000} +: 8] = tag.data_byte;
      KIND_CHECK:   header_sum_next[{tag.lane, 3'b000} +: 8]     = tag.data_byte;
      default: ;
    endcase
  end

  // adler-32 step, both sums reduced by one conditional subtract
  always_comb begin
    low_raw = {1'b0, sum_low} + {9'd0, tag.data_byte};
    low_red = (low_raw >= ADLER_MOD) ? (low_raw - ADLER_MOD) : low_raw;
    high_raw = {1'b0, sum_high} + low_red;
    if (tag.kind == KIND_PAYLOAD) begin
      sum_low_next  = low_red[15:0];
      sum_high_next = (high_raw >= ADLER_MOD) ? 16'(high_raw - ADLER_MOD)
                                              : high_raw[15:0];
    end else begin
      sum_low_next  = sum_low;
      sum_high_next = sum_high;
    end
    sum_word = {sum_high_next, sum_low_next};
  end

  // status, first failing check wins
  always_comb begin
    res.computed_sum = sum_word;
    if (tag.short_image) begin
      res.status = STATUS_TOO_SHORT;
    end else if (header_marker_next != expected_marker) begin
      res.status = STATUS_BAD_MARKER;
    end else if (!(header_version_next > installed_revision)) begin
      res.status = STATUS_OLD_VERSION;
    end else if (header_sum_next != sum_word) begin
      res.status = STATUS_SUM_MISMATCH;
    end else begin
      res.status = STATUS_OK;
    end
  end

  assign res_push = step && tag.last_byte;

  // image state, restarted after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      header_marker  <= '0;
      header_version <= '0;
      header_sum     <= '0;
      sum_low        <= 16'd1;
      sum_high       <= 16'd0;
    end else if (step) begin
      if (tag.last_byte) begin
        header_marker  <= '0;
        header_version <= '0;
        header_sum     <= '0;
        sum_low        <= 16'd1;
        sum_high       <= 16'd0;
      end else begin
        header_marker  <= header_marker_next;
        header_version <= header_version_next;
        header_sum     <= header_sum_next;
        sum_low        <= sum_low_next;
        sum_high       <= sum_high_next;
      end
    end
  end

endmodule

// File: sv/ihac_result_queue.sv
// two-entry result queue between the back part and the result port
// uses ihac_pkg for the result type
module ihac_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_push,
  output logic                 res_full,
  input  ihac_pkg::result_t    res,
  output logic                 empty,
  input  logic                 pop,
  output ihac_pkg::result_t    result
);
  import ihac_pkg::*;

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en;
  logic       rd_en;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign wr_en    = res_push && !res_full;
  assign rd_en    = pop && !empty;
  assign result   = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= res;
    end
  end

endmodule

// File: sv/image_header_adler32_checker.sv
// Firmware image checker: header capture plus adler-32 over the payload.
// Depends on ihac_pkg, ihac_front, ihac_back and ihac_result_queue.
//
// Usage:
//   Image bytes enter through push/full with item.data_byte and
//   item.last_byte; a byte is taken on a clock edge with push high and full
//   low. Bytes 0-15 are the little-endian header (marker, size, version,
//   stored checksum); every later byte feeds adler-32 (seed 1, mod 65521).
//   Each image ends with last_byte set and gives one result item on the
//   empty/pop side: a status code and the computed checksum.
//   Throughput is one byte per cycle while full stays low; each byte
//   takes one pass through the front queue and one step in the back part.
//   A result enters the result queue as the back part takes its last byte.
//   The expected marker and installed revision are written through
//   cfg_write/cfg_index/cfg_data while no image is in flight.
//   Reset (rst, synchronous) empties both queues, restarts the image state
//   and loads the register defaults.
//   When the receiver stops popping, the two-entry result queue fills, the
//   back part holds its byte, the front queue fills and full goes high.
module image_header_adler32_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  ihac_pkg::item_t               item,
  output logic                          empty,
  input  logic                          pop,
  output ihac_pkg::result_t             result,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [ihac_pkg::CFG_W-1:0]    cfg_data
);
  import ihac_pkg::*;

  logic [31:0] expected_marker;
  logic [31:0] installed_revision;
  logic        tag_valid;
  logic        tag_take;
  tagged_t     tag;
  logic        res_full;
  logic        res_push;
  result_t     res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_marker    <= MARKER_RESET;
      installed_revision <= REVISION_RESET;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_EXPECTED_MARKER:    expected_marker    <= cfg_data[31:0];
        CFG_INSTALLED_REVISION: installed_revision <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // byte intake and classification
  ihac_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .tag_valid (tag_valid),
    .tag_take  (tag_take),
    .tag       (tag)
  );

  // header capture, checksum and status
  ihac_back u_back (
    .clk                (clk),
    .rst                (rst),
    .tag_valid          (tag_valid),
    .tag_take           (tag_take),
    .tag                (tag),
    .expected_marker    (expected_marker),
    .installed_revision (installed_revision),
    .res_full           (res_full),
    .res_push           (res_push),
    .res                (res)
  );

  // result buffering
  ihac_result_queue u_result_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_full (res_full),
    .res      (res),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
